// ----- rtl/ahtfp_pkg.sv -----
`default_nettype none

package ahtfp_pkg;

  localparam int unsigned WinLen   = 15;
  localparam int unsigned FrameLen = 16;
  localparam int unsigned NumLen   = 5;
  localparam int unsigned ValW     = 15;
  localparam int unsigned MagW     = 14;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [7:0]             char_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_MIN = 3'd0,
    CFG_TEMP_MAX = 3'd1,
    CFG_HUM_MIN  = 3'd2,
    CFG_HUM_MAX  = 3'd3
  } cfg_idx_t;

  localparam val_t TempMinReset = -15'sd400;
  localparam val_t TempMaxReset = 15'sd800;
  localparam val_t HumMinReset  = 15'sd0;
  localparam val_t HumMaxReset  = 15'sd1000;

  localparam char_t ChR     = 8'h52;
  localparam char_t ChColon = 8'h3A;
  localparam char_t ChH     = 8'h48;
  localparam char_t ChSpace = 8'h20;
  localparam char_t ChC     = 8'h43;
  localparam char_t ChPlus  = 8'h2B;
  localparam char_t ChMinus = 8'h2D;
  localparam char_t ChPoint = 8'h2E;
  localparam char_t ChZero  = 8'h30;
  localparam char_t ChNine  = 8'h39;

  typedef struct packed {
    logic ok;
    val_t value;
  } num_res_t;

  function automatic logic is_digit(input char_t c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ahtfp_num.sv -----
`default_nettype none

module ahtfp_num
  import ahtfp_pkg::*;
(
  input  wire logic [NumLen-1:0][7:0] num_chars,
  output num_res_t                    num_res
);

  logic           lead_digit;
  logic           lead_plus;
  logic           lead_minus;
  logic [3:0]     d0;
  logic [3:0]     d1;
  logic [3:0]     d2;
  logic [3:0]     d4;
  logic [MagW-1:0] mag;
  val_t           pos;

  always_comb begin
    lead_digit = is_digit(num_chars[0]);
    lead_plus  = (num_chars[0] == ChPlus);
    lead_minus = (num_chars[0] == ChMinus);
    d0 = lead_digit ? num_chars[0][3:0] : 4'd0;
    d1 = num_chars[1][3:0];
    d2 = num_chars[2][3:0];
    d4 = num_chars[4][3:0];
    mag = MagW'(MagW'(d0) * MagW'(1000)) + MagW'(MagW'(d1) * MagW'(100))
        + MagW'(MagW'(d2) * MagW'(10)) + MagW'(d4);
    pos = val_t'({1'b0, mag});
    num_res.ok = is_digit(num_chars[1]) && is_digit(num_chars[2])
               && (num_chars[3] == ChPoint) && is_digit(num_chars[4])
               && (lead_digit || lead_plus || lead_minus);
    num_res.value = lead_minus ? -pos : pos;
  end

endmodule

`default_nettype wire

// ----- rtl/ascii_humidity_temperature_frame_parser_core.sv -----
// Frame parser for an ASCII sensor stream of the form "R:hhh.hRH ttt.tC".
// Input channel: one received byte per word (in_rx_byte) with in_buffer_end
// marking the last byte of a receive buffer. A word is taken when in_valid is
// high and in_stall is low.
// Output channel: exactly one result word per input word, taken when out_valid
// is high and out_stall is low. out_frame_valid flags the first in-range frame
// of a buffer and carries its values in tenths; out_buffer_done echoes the
// end flag and out_buffer_found tells whether the buffer held a good frame.
// Each result is registered in the output register, and a word can be taken
// every cycle unless the output word is stalled; the sustained rate is one
// byte per cycle, set by the single output register that holds each result.
// When the receiver stalls, the output register holds its word and in_stall
// rises in the same cycle, so no word is lost.
// Configuration: four limit registers written over cfg_valid/cfg_ready with
// cfg_ready always high; writes to indexes above three are dropped.
// Reset clears the byte window, the found flag and the output valid, and
// loads the default limits (-40.0 to 80.0 C, 0.0 to 100.0 %RH).
`default_nettype none

module ascii_humidity_temperature_frame_parser_core
  import ahtfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_buffer_end,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_frame_valid,
  output logic signed [ValW-1:0]  out_humidity_tenths,
  output logic signed [ValW-1:0]  out_temperature_tenths,
  output logic                    out_buffer_done,
  output logic                    out_buffer_found,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ValW-1:0]    cfg_data
);

  logic [WinLen-1:0][7:0]   win_r;
  logic [WinLen-1:0][7:0]   win_nxt;
  logic                     found_r;
  logic                     found_nxt;
  val_t                     temp_min_r;
  val_t                     temp_max_r;
  val_t                     hum_min_r;
  val_t                     hum_max_r;

  logic                     out_valid_r;
  logic                     frame_valid_r;
  val_t                     hum_r;
  val_t                     temp_r;
  logic                     done_r;
  logic                     found_out_r;

  logic [FrameLen-1:0][7:0] frame;
  logic [NumLen-1:0][7:0]   hum_chars;
  logic [NumLen-1:0][7:0]   temp_chars;
  num_res_t                 hum_res;
  num_res_t                 temp_res;
  logic                     fixed_ok;
  logic                     hit;
  logic                     in_take;

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      frame[i] = win_r[i];
    end
    frame[FrameLen-1] = in_rx_byte;
    for (int k = 0; k < NumLen; k++) begin
      hum_chars[k]  = frame[2+k];
      temp_chars[k] = frame[10+k];
    end
  end

  ahtfp_num u_hum_num (
    .num_chars (hum_chars),
    .num_res   (hum_res)
  );

  ahtfp_num u_temp_num (
    .num_chars (temp_chars),
    .num_res   (temp_res)
  );

  always_comb begin
    fixed_ok = (frame[0] == ChR) && (frame[1] == ChColon) && (frame[7] == ChR)
             && (frame[8] == ChH) && (frame[9] == ChSpace)
             && (frame[FrameLen-1] == ChC);
    hit = fixed_ok && hum_res.ok && temp_res.ok
        && (temp_res.value >= temp_min_r) && (temp_res.value <= temp_max_r)
        && (hum_res.value >= hum_min_r) && (hum_res.value <= hum_max_r)
        && !found_r;
    if (in_buffer_end) begin
      win_nxt   = '0;
      found_nxt = 1'b0;
    end else begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WinLen-1] = in_rx_byte;
      found_nxt = found_r || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        win_r   <= win_nxt;
        found_r <= found_nxt;
      end
      if (in_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frame_valid_r <= hit;
      hum_r         <= hit ? hum_res.value : '0;
      temp_r        <= hit ? temp_res.value : '0;
      done_r        <= in_buffer_end;
      found_out_r   <= in_buffer_end && (found_r || hit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_min_r <= TempMinReset;
      temp_max_r <= TempMaxReset;
      hum_min_r  <= HumMinReset;
      hum_max_r  <= HumMaxReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_MIN: begin
          temp_min_r <= val_t'(cfg_data);
        end
        CFG_TEMP_MAX: begin
          temp_max_r <= val_t'(cfg_data);
        end
        CFG_HUM_MIN: begin
          hum_min_r <= val_t'(cfg_data);
        end
        CFG_HUM_MAX: begin
          hum_max_r <= val_t'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frame_valid        = frame_valid_r;
  assign out_humidity_tenths    = hum_r;
  assign out_temperature_tenths = temp_r;
  assign out_buffer_done        = done_r;
  assign out_buffer_found       = found_out_r;

  // A reported frame inside a buffer leaves the found flag set behind it.
  a_found_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_valid_r && !done_r) |-> found_r)
    else $error("found flag not set after a reported frame");

  // The closing byte of a buffer leaves the found flag clear.
  a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> !found_r)
    else $error("found flag not cleared at buffer end");

  // Values are zero unless a frame is reported.
  a_zero_vals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !frame_valid_r) |-> (hum_r == '0 && temp_r == '0))
    else $error("nonzero values without a frame");

  // A frame reported on the closing byte counts as found for the buffer.
  a_end_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_valid_r && done_r) |-> found_out_r)
    else $error("buffer_found missing for a frame on the closing byte");

  // Every accepted word yields a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("no result after an accepted word");

endmodule

`default_nettype wire

// ----- dv/ahtfp_frame_checker.sv -----
`timescale 1ns / 1ps

module ahtfp_frame_checker
  import ahtfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_buffer_end,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               out_frame_valid,
  input  wire logic [ValW-1:0]    out_humidity_tenths,
  input  wire logic [ValW-1:0]    out_temperature_tenths,
  input  wire logic               out_buffer_done,
  input  wire logic               out_buffer_found,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ValW-1:0]    cfg_data,
  output int                      mismatches,
  output int                      words_awaited,
  output int                      frames_reported,
  output int                      buffers_closed
);

  typedef struct {
    logic frame_valid;
    val_t humidity;
    val_t temperature;
    logic done;
    logic found;
  } frame_result_t;

  char_t         window_q [WinLen];
  char_t         frame_bytes [FrameLen];
  bit            frame_seen = 1'b0;
  val_t          temp_lo = TempMinReset;
  val_t          temp_hi = TempMaxReset;
  val_t          hum_lo  = HumMinReset;
  val_t          hum_hi  = HumMaxReset;
  frame_result_t awaited_results [$];
  frame_result_t oldest;

  initial begin
    mismatches      = 0;
    words_awaited   = 0;
    frames_reported = 0;
    buffers_closed  = 0;
    foreach (window_q[i]) window_q[i] = 8'h00;
  end

  function automatic bit is_numeral(input char_t c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic int numeral_value(input char_t c);
    return int'(c) - int'(ChZero);
  endfunction

  function automatic bit decode_tenths(input int at, output int tenths);
    int magnitude;
    bit negative;
    tenths    = 0;
    magnitude = 0;
    negative  = 1'b0;
    if (!is_numeral(frame_bytes[at+1]) || !is_numeral(frame_bytes[at+2]) ||
        frame_bytes[at+3] != ChPoint || !is_numeral(frame_bytes[at+4])) begin
      return 1'b0;
    end
    if (is_numeral(frame_bytes[at])) begin
      magnitude = 1000 * numeral_value(frame_bytes[at]);
    end else if (frame_bytes[at] == ChMinus) begin
      negative = 1'b1;
    end else if (frame_bytes[at] != ChPlus) begin
      return 1'b0;
    end
    magnitude += 100 * numeral_value(frame_bytes[at+1]) +
                 10 * numeral_value(frame_bytes[at+2]) + numeral_value(frame_bytes[at+4]);
    tenths = negative ? -magnitude : magnitude;
    return 1'b1;
  endfunction

  function automatic frame_result_t parse_next_byte(input char_t b, input logic last);
    frame_result_t r;
    int hum;
    int temp;
    bit ok;
    hum  = 0;
    temp = 0;
    for (int i = 0; i < WinLen; i++) frame_bytes[i] = window_q[i];
    frame_bytes[WinLen] = b;
    ok = frame_bytes[0] == ChR && frame_bytes[1] == ChColon && frame_bytes[7] == ChR &&
         frame_bytes[8] == ChH && frame_bytes[9] == ChSpace && frame_bytes[15] == ChC;
    if (ok) ok = decode_tenths(2, hum);
    if (ok) ok = decode_tenths(10, temp);
    if (ok) begin
      ok = temp >= temp_lo && temp <= temp_hi && hum >= hum_lo && hum <= hum_hi && !frame_seen;
    end
    if (ok) begin
      frame_seen = 1'b1;
    end else begin
      hum  = 0;
      temp = 0;
    end
    r.frame_valid = ok;
    r.humidity    = val_t'(hum);
    r.temperature = val_t'(temp);
    r.done        = last;
    r.found       = last && frame_seen;
    if (last) begin
      foreach (window_q[i]) window_q[i] = 8'h00;
      frame_seen = 1'b0;
    end else begin
      for (int i = 0; i < WinLen - 1; i++) window_q[i] = window_q[i+1];
      window_q[WinLen-1] = b;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatches++;
    $display("%0t: %s is %0d, predicted %0d", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP_MIN: temp_lo = val_t'(cfg_data);
          CFG_TEMP_MAX: temp_hi = val_t'(cfg_data);
          CFG_HUM_MIN:  hum_lo  = val_t'(cfg_data);
          CFG_HUM_MAX:  hum_hi  = val_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(parse_next_byte(in_rx_byte, in_buffer_end));
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with none awaited", 1, 0);
        end else begin
          oldest = awaited_results.pop_front();
          if (out_frame_valid !== oldest.frame_valid)
            report_mismatch("frame_valid", out_frame_valid, oldest.frame_valid);
          if (val_t'(out_humidity_tenths) !== oldest.humidity)
            report_mismatch("humidity_tenths", val_t'(out_humidity_tenths), oldest.humidity);
          if (val_t'(out_temperature_tenths) !== oldest.temperature)
            report_mismatch("temperature_tenths", val_t'(out_temperature_tenths),
                            oldest.temperature);
          if (out_buffer_done !== oldest.done)
            report_mismatch("buffer_done", out_buffer_done, oldest.done);
          if (out_buffer_found !== oldest.found)
            report_mismatch("buffer_found", out_buffer_found, oldest.found);
          if (oldest.frame_valid) frames_reported++;
          if (oldest.done) buffers_closed++;
        end
      end
      words_awaited = awaited_results.size();
    end
  end

endmodule

// ----- dv/ascii_humidity_temperature_frame_parser_core_test.sv -----
`timescale 1ns / 1ps

module ascii_humidity_temperature_frame_parser_core_test;
  import ahtfp_pkg::*;

  localparam int                 HalfPeriod  = 6;
  localparam int                 MaxGap      = 17;
  localparam int                 PhaseBytes  = 160;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 3'd7;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [7:0]         in_rx_byte    = 8'h00;
  logic               in_buffer_end = 1'b0;
  logic               out_stall     = 1'b0;
  logic               cfg_valid     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index     = '0;
  logic [ValW-1:0]    cfg_data      = '0;

  logic            in_stall;
  logic            out_valid;
  logic            out_frame_valid;
  logic [ValW-1:0] out_humidity_tenths;
  logic [ValW-1:0] out_temperature_tenths;
  logic            out_buffer_done;
  logic            out_buffer_found;
  logic            cfg_ready;

  int mismatches;
  int words_awaited;
  int frames_reported;
  int buffers_closed;
  int bytes_sent     = 0;
  int settings_used  = 1;
  bit in_calm        = 1'b0;
  bit out_calm       = 1'b0;

  val_t aim_temp_lo = TempMinReset;
  val_t aim_temp_hi = TempMaxReset;
  val_t aim_hum_lo  = HumMinReset;
  val_t aim_hum_hi  = HumMaxReset;

  always #HalfPeriod clk = ~clk;

  ascii_humidity_temperature_frame_parser_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .in_buffer_end          (in_buffer_end),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_frame_valid        (out_frame_valid),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .out_buffer_done        (out_buffer_done),
    .out_buffer_found       (out_buffer_found),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  ahtfp_frame_checker frame_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .in_buffer_end          (in_buffer_end),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_frame_valid        (out_frame_valid),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .out_buffer_done        (out_buffer_done),
    .out_buffer_found       (out_buffer_found),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .mismatches             (mismatches),
    .words_awaited          (words_awaited),
    .frames_reported        (frames_reported),
    .buffers_closed         (buffers_closed)
  );

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, MaxGap));
  endfunction

  function automatic string number_text(input int v, input bit plus);
    if (v < 0) return $sformatf("-%02d.%0d", (-v) / 10, (-v) % 10);
    if (plus && v <= 999) return $sformatf("+%02d.%0d", v / 10, v % 10);
    return $sformatf("%03d.%0d", v / 10, v % 10);
  endfunction

  function automatic int pick_value(input val_t lo, input val_t hi);
    int v;
    case ($urandom_range(0, 3))
      0: v = -999 + int'($urandom_range(0, 10998));
      1: v = int'(lo) + int'($urandom_range(0, 4)) - 2;
      2: v = int'(hi) + int'($urandom_range(0, 4)) - 2;
      default: begin
        if (hi >= lo) v = int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo)));
        else v = int'(lo);
      end
    endcase
    if (v < -999) v = -999;
    if (v > 9999) v = 9999;
    return v;
  endfunction

  task automatic send_byte(input char_t b, input logic last);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_buffer_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer(input char_t bytes [$]);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    char_t bytes [$];
    for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
    send_buffer(bytes);
  endtask

  task automatic send_random_buffer();
    char_t bytes [$];
    string frame_text;
    int    choice;
    int    cut;
    repeat ($urandom_range(1, 4)) begin
      frame_text = {"R:", number_text(pick_value(aim_hum_lo, aim_hum_hi),
                                      $urandom_range(0, 3) == 0),
                    "RH ", number_text(pick_value(aim_temp_lo, aim_temp_hi),
                                       $urandom_range(0, 3) == 0), "C"};
      choice = $urandom_range(0, 9);
      if (choice == 7) begin
        cut = $urandom_range(1, FrameLen - 1);
        for (int i = 0; i < cut; i++) bytes.push_back(frame_text[i]);
      end else if (choice >= 8) begin
        repeat ($urandom_range(1, 6)) bytes.push_back(char_t'($urandom_range(0, 255)));
      end else begin
        for (int i = 0; i < frame_text.len(); i++) bytes.push_back(frame_text[i]);
        if (choice == 6) begin
          bytes[bytes.size() - 1 - $urandom_range(0, FrameLen - 1)] =
            char_t'($urandom_range(0, 255));
        end
      end
    end
    send_buffer(bytes);
  endtask

  task automatic run_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) send_random_buffer();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (words_awaited == 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input val_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_limits(input val_t t_lo, input val_t t_hi, input val_t h_lo,
                            input val_t h_hi);
    settle();
    write_limit(CFG_TEMP_MIN, t_lo);
    write_limit(CFG_TEMP_MAX, t_hi);
    write_limit(CFG_HUM_MIN, h_lo);
    write_limit(CFG_HUM_MAX, h_hi);
    cfg_valid <= 1'b0;
    aim_temp_lo = t_lo;
    aim_temp_hi = t_hi;
    aim_hum_lo  = h_lo;
    aim_hum_hi  = h_hi;
    settings_used++;
  endtask

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    val_t lo;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("R:000.0RH -40.0C");
    send_text("R:100.0RH 080.0CR:050.0RH +12.3C");
    send_text("R:050.0RH");
    send_text(" 020.0C");
    send_text("R:100.1RH -40.1C");
    send_text("R:999.9RH -99.9CR:05a.0RH 020.0C");
    send_text("R:050,0RH 020.0CR:050.0RH*020.0C");
    send_text("R:+99.9RH 7.0.0CR:+99.9RH 000.0C");
    send_buffer('{8'h00, 8'hFF, ChR, ChColon, 8'h80, 8'h7F});

    run_phase();
    set_limits(-15'sd999, 15'sd9999, -15'sd999, 15'sd9999);
    run_phase();
    set_limits(-15'sd16384, 15'sd16383, -15'sd16384, 15'sd16383);
    @(posedge clk);
    write_limit(CfgSpareIdx, val_t'($urandom_range(0, 16383)));
    cfg_valid <= 1'b0;
    run_phase();
    set_limits(15'sd500, 15'sd100, 15'sd900, 15'sd200);
    run_phase();
    set_limits(15'sd250, 15'sd250, 15'sd455, 15'sd455);
    run_phase();
    lo = val_t'(-999 + int'($urandom_range(0, 5000)));
    set_limits(lo, val_t'(int'(lo) + int'($urandom_range(0, 4000))), -15'sd50,
               val_t'($urandom_range(300, 1200)));
    run_phase();

    in_valid <= 1'b0;
    @(negedge clk);
    wait (words_awaited == 0);
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes in %0d buffers under %0d limit settings.",
             bytes_sent, buffers_closed, settings_used);
    $display("The block reported %0d accepted frames.", frames_reported);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
